// File: hw/rtl/lifo_stack_allocator_assert.svh
// ----------------------------------------------------------------------------
// LIFO stack allocator assertion macros
// Concurrent assertion wrappers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef LIFO_STACK_ALLOCATOR_ASSERT_SVH
`define LIFO_STACK_ALLOCATOR_ASSERT_SVH

// checked on every clock edge, held off while in reset
`define LSA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("lsa assertion failed");

// checked on every clock edge, reset included
`define LSA_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("lsa assertion failed");

`endif

// File: hw/rtl/lsa_pkg.sv
// ----------------------------------------------------------------------------
// LIFO stack allocator package
// Shared constants, command codes and FSM state type.
// ----------------------------------------------------------------------------
package lsa_pkg;

  localparam int unsigned MaxBlocksDef   = 256;
  localparam int unsigned HeaderBytesDef = 16;

  typedef enum logic [1:0] {
    CmdAcquire = 2'd0,
    CmdRelease = 2'd1,
    CmdRewind  = 2'd2
  } cmd_e;

  typedef enum logic {
    StIdle = 1'b0,
    StExec = 1'b1
  } state_e;

endpackage

// File: hw/rtl/lifo_stack_allocator.sv
// ----------------------------------------------------------------------------
// LIFO stack allocator
// Bump allocator with a size stack held in a synchronous RAM.
// ----------------------------------------------------------------------------
// The result strobe is registered from StExec, the state entered on the start transfer.
// A new command is accepted only in StIdle; busy is high in StExec. The top-of-stack
// RAM read is issued in the accept cycle; the stack write is done in the execute cycle.
// The result is shown for one cycle on done_o; the receiver cannot stall.
// Reset clears cursor, block count and region size; the RAM is not cleared.
// ----------------------------------------------------------------------------
`include "lifo_stack_allocator_assert.svh"

module lifo_stack_allocator
  import lsa_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS   = MaxBlocksDef,
  parameter int unsigned HEADER_BYTES = HeaderBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd_i,
  input  logic [31:0] req_bytes_i,
  input  logic [31:0] block_offset_i,
  input  logic        block_is_null_i,
  input  logic        region_bytes_we_i,
  input  logic [31:0] region_bytes_i,
  output logic        done_o,
  output logic        ok_o,
  output logic [31:0] granted_offset_o,
  output logic [31:0] free_bytes_o
);

  localparam int unsigned AddrW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CntW  = $clog2(MAX_BLOCKS + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_BLOCKS);
  localparam logic [32:0]     Hdr33  = 33'(HEADER_BYTES);
  localparam logic [31:0]     Hdr32  = 32'(HEADER_BYTES);

  state_e state_q, state_d;

  logic [1:0]      cmd_q;
  logic [31:0]     req_q;
  logic [31:0]     off_q;
  logic            null_q;
  logic [31:0]     region_q;
  logic [31:0]     cursor_q, cursor_d;
  logic [CntW-1:0] count_q, count_d;
  logic            done_q, done_d;
  logic            ok_q, ok_d;
  logic [31:0]     granted_q, granted_d;

  logic            accept;
  logic            ram_we;
  logic [31:0]     top_size;
  logic [CntW-1:0] count_m1;

  assign accept   = start && (state_q == StIdle);
  assign busy     = (state_q != StIdle);
  assign count_m1 = count_q - CntW'(1);

  lsa_ram #(
    .Width(32),
    .Depth(MAX_BLOCKS)
  ) u_stack_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(count_q[AddrW-1:0]),
    .wdata_i(req_q),
    .re_i   (accept),
    .raddr_i(count_m1[AddrW-1:0]),
    .rdata_o(top_size)
  );

  // payload capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= cmd_i;
      req_q  <= req_bytes_i;
      off_q  <= block_offset_i;
      null_q <= block_is_null_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      region_q  <= '0;
      cursor_q  <= '0;
      count_q   <= '0;
      done_q    <= 1'b0;
      ok_q      <= 1'b0;
      granted_q <= '0;
    end else begin
      state_q   <= state_d;
      cursor_q  <= cursor_d;
      count_q   <= count_d;
      done_q    <= done_d;
      ok_q      <= ok_d;
      granted_q <= granted_d;
      if (region_bytes_we_i) begin
        region_q <= region_bytes_i;
      end
    end
  end

  always_comb begin
    logic [32:0] full;
    logic [32:0] blk_end;
    logic [31:0] head;
    logic [32:0] top_end;
    full      = {1'b0, req_q} + Hdr33;
    blk_end   = {1'b0, cursor_q} + full;
    head      = off_q - Hdr32;
    top_end   = {1'b0, off_q} + {1'b0, top_size};
    state_d   = state_q;
    cursor_d  = cursor_q;
    count_d   = count_q;
    done_d    = 1'b0;
    ok_d      = ok_q;
    granted_d = granted_q;
    ram_we    = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StExec;
        end
      end
      StExec: begin
        state_d   = StIdle;
        done_d    = 1'b1;
        ok_d      = 1'b0;
        granted_d = '0;
        unique case (cmd_q)
          CmdAcquire: begin
            if ((req_q != '0) && !full[32] && (blk_end <= {1'b0, region_q}) &&
                (count_q < CntMax)) begin
              ram_we    = 1'b1;
              granted_d = cursor_q + Hdr32;
              cursor_d  = blk_end[31:0];
              count_d   = count_q + CntW'(1);
              ok_d      = 1'b1;
            end
          end
          CmdRelease: begin
            if (null_q) begin
              ok_d = 1'b1;
            end else if ((off_q >= Hdr32) && (head < region_q) &&
                         (count_q != '0) && (top_end == {1'b0, cursor_q})) begin
              cursor_d = head;
              count_d  = count_m1;
              ok_d     = 1'b1;
            end
          end
          CmdRewind: begin
            cursor_d = '0;
            count_d  = '0;
            ok_d     = (region_q != '0);
          end
          default: begin
            ok_d = 1'b0;
          end
        endcase
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // free space after the operation, from the updated state
  always_comb begin
    logic [31:0] room;
    room = region_q - cursor_q;
    if ((count_q >= CntMax) || (cursor_q >= region_q) || (room <= Hdr32)) begin
      free_bytes_o = '0;
    end else begin
      free_bytes_o = room - Hdr32;
    end
  end

  assign done_o           = done_q;
  assign ok_o             = ok_q;
  assign granted_offset_o = granted_q;

  `LSA_ASSERT(a_exec_strobes, clk_i, rst_ni, (state_q == StExec) |=> done_q)
  `LSA_ASSERT(a_accept_busy, clk_i, rst_ni, accept |=> (busy && !done_q))
  `LSA_ASSERT(a_grant_only_ok, clk_i, rst_ni, (done_q && !ok_q) |-> (granted_q == '0))
  `LSA_ASSERT(a_push_count, clk_i, rst_ni,
              (done_q && ok_q && (cmd_q == CmdAcquire)) |->
              (count_q == $past(count_q) + CntW'(1)))
  `LSA_ASSERT_ALWAYS(a_count_bound, clk_i, !rst_ni || (count_q <= CntMax))

endmodule

// File: hw/rtl/lsa_ram.sv
// ----------------------------------------------------------------------------
// LIFO stack allocator RAM
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lsa_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
